/* rtl/core/bqab_pkg.sv */
// shared types, constants and slot arithmetic for the retransmit queue
// used by bounded_queue_with_ack_backlog_top; depends on nothing
package bqab_pkg;

	// ring geometry
	localparam int RING_DEPTH = 64;
	localparam int SLOT_W     = $clog2(RING_DEPTH);
	localparam int CNT_W      = 7;
	localparam int SUM_W      = CNT_W + 1;
	localparam int BYTES_W    = 22;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BACKLOG_EN  = 1'b1;

	localparam logic [CNT_W-1:0] QUEUE_LIMIT_RESET = 7'd64;

	// request codes
	typedef enum logic [2:0] {
		REQ_PUSH_TAIL  = 3'd0,
		REQ_PUSH_HEAD  = 3'd1,
		REQ_POP        = 3'd2,
		REQ_ACK        = 3'd3,
		REQ_REWIND     = 3'd4,
		REQ_REWIND_ALL = 3'd5
	} req_kind_t;

	// result codes
	typedef enum logic [2:0] {
		OUT_ACCEPTED     = 3'd0,
		OUT_DELIVERED    = 3'd1,
		OUT_EMPTY        = 3'd2,
		OUT_DROP_SUSPEND = 3'd3,
		OUT_DROP_PROCESS = 3'd4,
		OUT_ACKED        = 3'd5,
		OUT_REFUSED      = 3'd6
	} outcome_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_ACK_RD,
		S_ACK_WB,
		S_RW_RD,
		S_RW_WB
	} state_t;

	typedef struct packed {
		logic [2:0]       req_type;
		logic [31:0]      msg_handle;
		logic [15:0]      msg_bytes;
		logic             needs_ack;
		logic             flow_controlled;
		logic [CNT_W-1:0] entry_count;
	} req_t;

	typedef struct packed {
		outcome_t           outcome;
		logic [31:0]        out_handle;
		logic               out_needs_ack;
		logic               last;
		logic [CNT_W-1:0]   queued_now;
		logic [CNT_W-1:0]   backlog_now;
		logic [BYTES_W-1:0] queued_bytes;
		logic [31:0]        drop_total;
	} result_t;

	// one ring slot
	typedef struct packed {
		logic [31:0] handle;
		logic [15:0] size;
		logic        needs_ack;
	} entry_t;

	// slot that lies offset places after base, modulo the ring depth
	function automatic logic [SLOT_W-1:0] slot_at(input logic [SLOT_W-1:0] base,
			input logic [CNT_W-1:0] offset);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(offset);
		if (sum >= SUM_W'(RING_DEPTH)) begin
			sum = sum - SUM_W'(RING_DEPTH);
		end
		return SLOT_W'(sum);
	endfunction

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
	endfunction

	function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
		return (s == '0) ? SLOT_W'(RING_DEPTH - 1) : s - SLOT_W'(1);
	endfunction

endpackage

/* rtl/core/bqab_ram.sv */
// generic single-write, single-read ram with registered read data
// stand-alone; no package needed
module bqab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/bounded_queue_with_ack_backlog_top.sv */
// top level of the retransmit queue with acknowledgement backlog and rewind
// depends on bqab_pkg and bqab_ram
//
// A request is taken at a clock edge with start high and busy low. Each result is
// shown for exactly one cycle with result_valid high and cannot be held off.
// Push-tail, push-head, pop and refused requests give their single result, registered
// from the S_EXEC state, and free busy as they leave it. Ack of n entries passes
// S_ACK_RD and S_ACK_WB once per entry with one result per entry; rewind of n entries
// passes S_RW_RD and S_RW_WB once per entry with a single result at the end; an ack
// that frees nothing gives no result. The walk is set by the one ring ram: a single
// registered read port, so every walked entry needs an address state and a data
// state. No clearing pass is needed after reset. Configuration writes on cfg_we are
// taken in any cycle, but are only meant while the block is idle.
module bounded_queue_with_ack_backlog_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  bqab_pkg::req_t                req,
	output logic                          busy,
	output logic                          result_valid,
	output bqab_pkg::result_t             result,
	input  logic                          cfg_we,
	input  logic [bqab_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bqab_pkg::CFG_DATA_W-1:0] cfg_data
);

	import bqab_pkg::*;

	state_t             state_q, state_d;
	req_t               req_q, req_d;
	logic [SLOT_W-1:0]  oldest_q, oldest_d;
	logic [CNT_W-1:0]   backlog_q, backlog_d;
	logic [CNT_W-1:0]   queued_q, queued_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [BYTES_W-1:0] bytes_q, bytes_d, addend;
	logic [31:0]        drop_q, drop_d;
	logic [CNT_W-1:0]   queue_limit_q;
	logic               backlog_en_q;
	logic [CNT_W-1:0]   used;
	logic [CNT_W-1:0]   clamp_n;

	logic               ram_we;
	logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
	entry_t             ram_wdata, ram_rdata;

	logic               emit;
	result_t            res_d, result_q;
	logic               result_valid_q;

	// ring storage
	bqab_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_limit_q <= QUEUE_LIMIT_RESET;
			backlog_en_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUEUE_LIMIT: queue_limit_q <= cfg_data;
				REG_BACKLOG_EN:  backlog_en_q  <= cfg_data[0];
			endcase
		end
	end

	assign used    = queued_q + backlog_q;
	assign clamp_n = (req_q.entry_count < backlog_q) ? req_q.entry_count : backlog_q;

	// shared byte accumulator
	assign bytes_d = bytes_q + addend;

	// sequencer: next state, ring access and result
	always_comb begin
		state_d   = state_q;
		req_d     = req_q;
		oldest_d  = oldest_q;
		backlog_d = backlog_q;
		queued_d  = queued_q;
		cnt_d     = cnt_q;
		drop_d    = drop_q;
		addend    = '0;

		ram_we    = 1'b0;
		ram_waddr = slot_at(oldest_q, used);
		ram_wdata = '{handle: req_q.msg_handle, size: req_q.msg_bytes,
			needs_ack: req_q.needs_ack};
		ram_raddr = slot_at(oldest_q, backlog_q);

		emit              = 1'b0;
		res_d.outcome     = OUT_ACCEPTED;
		res_d.out_handle  = '0;
		res_d.out_needs_ack = 1'b0;
		res_d.last        = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				// head entry is read ahead for a pop
				if (start) begin
					req_d   = req;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				unique case (req_q.req_type)
					REQ_PUSH_TAIL: begin
						emit                = 1'b1;
						res_d.out_handle    = req_q.msg_handle;
						res_d.out_needs_ack = req_q.needs_ack;
						if (queued_q >= queue_limit_q || used >= CNT_W'(RING_DEPTH)) begin
							drop_d        = drop_q + 32'd1;
							res_d.outcome = req_q.flow_controlled ? OUT_DROP_SUSPEND
								: OUT_DROP_PROCESS;
						end else begin
							ram_we   = 1'b1;
							queued_d = queued_q + CNT_W'(1);
							addend   = BYTES_W'(req_q.msg_bytes);
						end
					end
					REQ_PUSH_HEAD: begin
						emit = 1'b1;
						if (backlog_q != '0 || used >= CNT_W'(RING_DEPTH)) begin
							res_d.outcome = OUT_REFUSED;
						end else begin
							oldest_d            = slot_dec(oldest_q);
							ram_we              = 1'b1;
							ram_waddr           = slot_dec(oldest_q);
							queued_d            = queued_q + CNT_W'(1);
							addend              = BYTES_W'(req_q.msg_bytes);
							res_d.out_handle    = req_q.msg_handle;
							res_d.out_needs_ack = req_q.needs_ack;
						end
					end
					REQ_POP: begin
						emit = 1'b1;
						if (queued_q == '0) begin
							res_d.outcome = OUT_EMPTY;
						end else begin
							queued_d = queued_q - CNT_W'(1);
							addend   = BYTES_W'(0) - BYTES_W'(ram_rdata.size);
							if (backlog_en_q || backlog_q != '0) begin
								backlog_d = backlog_q + CNT_W'(1);
							end else begin
								oldest_d = slot_inc(oldest_q);
							end
							res_d.outcome       = OUT_DELIVERED;
							res_d.out_handle    = ram_rdata.handle;
							res_d.out_needs_ack = ram_rdata.needs_ack;
						end
					end
					REQ_ACK: begin
						// nothing to free gives no result
						if (clamp_n != '0) begin
							cnt_d   = clamp_n;
							state_d = S_ACK_RD;
						end
					end
					REQ_REWIND, REQ_REWIND_ALL: begin
						cnt_d = (req_q.req_type == REQ_REWIND_ALL) ? backlog_q : clamp_n;
						if (cnt_d == '0) begin
							emit = 1'b1;
						end else begin
							state_d = S_RW_RD;
						end
					end
					default: begin
						emit          = 1'b1;
						res_d.outcome = OUT_REFUSED;
					end
				endcase
			end
			S_ACK_RD: begin
				ram_raddr = oldest_q;
				state_d   = S_ACK_WB;
			end
			S_ACK_WB: begin
				// free the oldest backlog entry
				emit                = 1'b1;
				res_d.outcome       = OUT_ACKED;
				res_d.out_handle    = ram_rdata.handle;
				res_d.out_needs_ack = ram_rdata.needs_ack;
				res_d.last          = (cnt_q == CNT_W'(1));
				oldest_d            = slot_inc(oldest_q);
				backlog_d           = backlog_q - CNT_W'(1);
				cnt_d               = cnt_q - CNT_W'(1);
				state_d             = (cnt_q == CNT_W'(1)) ? S_IDLE : S_ACK_RD;
			end
			S_RW_RD: begin
				ram_raddr = slot_at(oldest_q, backlog_q - CNT_W'(1));
				state_d   = S_RW_WB;
			end
			S_RW_WB: begin
				// newest backlog entry goes back to the queue head
				addend    = BYTES_W'(ram_rdata.size);
				backlog_d = backlog_q - CNT_W'(1);
				queued_d  = queued_q + CNT_W'(1);
				cnt_d     = cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_RW_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		res_d.queued_now   = queued_d;
		res_d.backlog_now  = backlog_d;
		res_d.queued_bytes = bytes_d;
		res_d.drop_total   = drop_d;
	end

	// state register and queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			oldest_q  <= '0;
			backlog_q <= '0;
			queued_q  <= '0;
			bytes_q   <= '0;
			drop_q    <= '0;
			cnt_q     <= '0;
		end else begin
			state_q   <= state_d;
			oldest_q  <= oldest_d;
			backlog_q <= backlog_d;
			queued_q  <= queued_d;
			bytes_q   <= bytes_d;
			drop_q    <= drop_d;
			cnt_q     <= cnt_d;
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		req_q <= req_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= res_d;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ring never holds more than its depth
	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(queued_q + backlog_q) <= CNT_W'(RING_DEPTH))
		else $error("ring occupancy above depth");

	// results only come out of a working cycle
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q != S_IDLE))
		else $error("result without a request in progress");

	// an ack step always has a backlog entry and a count left
	a_ack_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACK_WB) |-> (backlog_q != '0 && cnt_q != '0))
		else $error("ack step with empty backlog");

	// each drop result advances the drop count by one
	a_drop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.outcome == OUT_DROP_SUSPEND
			|| result.outcome == OUT_DROP_PROCESS))
		|-> (result.drop_total == $past(drop_q) + 32'd1))
		else $error("drop count out of step");

endmodule
